// File: hdl/fpr_pkg.sv
// Shared constants, types and the microcode table of the FIFO page replacement block.
// No dependencies; imported by fpr_seq and fifo_page_replacement.
package fpr_pkg;

  localparam int FRAMES  = 16;
  localparam int IDX_W   = $clog2(FRAMES);
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int PAGE_W  = 16;
  localparam int CFG_W   = 5;
  localparam int TOTAL_W = 32;
  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 5'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_EMIT
  } step_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT_IN,
    C_EMPTY,
    C_SCAN,
    C_WAIT_OUT
  } cond_e;

  typedef struct packed {
    cond_e cond;
    step_e jmp;
    step_e nxt;
    logic  ld;
    logic  rd0;
    logic  scan;
    logic  hit;
    logic  miss;
    logic  emit;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic empty;
    logic match;
    logic last;
    logic out_free;
  } status_t;

  function automatic uword_t ucode_rom(input step_e s);
    uword_t w;
    w = '{cond: C_NEXT, jmp: ST_IDLE, nxt: ST_IDLE, default: 1'b0};
    case (s)
      ST_IDLE: begin
        w.cond = C_WAIT_IN;
        w.nxt  = ST_START;
        w.ld   = 1'b1;
      end
      ST_START: begin
        w.cond = C_EMPTY;
        w.jmp  = ST_MISS;
        w.nxt  = ST_SCAN;
        w.rd0  = 1'b1;
      end
      ST_SCAN: begin
        w.cond = C_SCAN;
        w.jmp  = ST_HIT;
        w.nxt  = ST_MISS;
        w.scan = 1'b1;
      end
      ST_HIT: begin
        w.nxt = ST_EMIT;
        w.hit = 1'b1;
      end
      ST_MISS: begin
        w.nxt  = ST_EMIT;
        w.miss = 1'b1;
      end
      ST_EMIT: begin
        w.cond = C_WAIT_OUT;
        w.nxt  = ST_IDLE;
        w.emit = 1'b1;
      end
      default: begin
        w.nxt = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hdl/fpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hdl/fpr_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on fpr_pkg.
module fpr_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fpr_pkg::status_t sts_i,
  output fpr_pkg::uword_t  ctl_o
);
  import fpr_pkg::*;

  step_e  step_q, step_d;
  uword_t uw;

  assign uw    = ucode_rom(step_q);
  assign ctl_o = uw;

  always_comb begin
    case (uw.cond)
      C_NEXT:     step_d = uw.nxt;
      C_WAIT_IN:  step_d = sts_i.accept ? uw.nxt : step_q;
      C_EMPTY:    step_d = sts_i.empty ? uw.jmp : uw.nxt;
      C_SCAN:     step_d = sts_i.match ? uw.jmp : (sts_i.last ? uw.nxt : step_q);
      C_WAIT_OUT: step_d = sts_i.out_free ? uw.nxt : step_q;
      default:    step_d = uw.nxt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: hdl/fifo_page_replacement.sv
// Top level of the FIFO page replacement block: datapath, frame RAM and result register.
// Depends on fpr_pkg, fpr_ram and fpr_seq.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   in       | input     | in_valid_i / in_stall_o | page_i
//   out      | output    | out_valid_o/out_stall_i | fault_o, slot_o, fault_total_o
//   cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_frame_count_i
//
// A request compares L resident frames (0 to 16, the filled frames up to the active
// count); the frame RAM is scanned one entry per cycle through its read port.
// Reset clears frame fill count, replace pointer, fault total and sets frame_count to 3.
// A new request is taken while the previous result waits; a stalled output holds
// the sequencer in its emit step until the result register frees.
module fifo_page_replacement (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fpr_pkg::PAGE_W-1:0]  page_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        fault_o,
  output logic [fpr_pkg::IDX_W-1:0]   slot_o,
  output logic [fpr_pkg::TOTAL_W-1:0] fault_total_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fpr_pkg::CFG_W-1:0]   cfg_frame_count_i
);
  import fpr_pkg::*;

  uword_t  ctl;
  status_t sts;

  logic [CFG_W-1:0]   cfg_q;
  logic [CNT_W-1:0]   filled_q;
  logic [IDX_W-1:0]   ptr_q;
  logic [TOTAL_W-1:0] count_q;
  logic               out_valid_q;

  logic [PAGE_W-1:0]  page_q;
  logic [CNT_W-1:0]   n_q;
  logic [CNT_W-1:0]   limit_q;
  logic [CNT_W-1:0]   addr_q;
  logic               fault_q;
  logic [IDX_W-1:0]   slot_q;

  logic [CNT_W-1:0]   n_act;
  logic [CNT_W-1:0]   limit_act;
  logic               accept;
  logic               scan_go;
  logic               emit_go;
  logic               fill;
  logic [IDX_W-1:0]   ptr_use;
  logic [CNT_W-1:0]   ptr_inc;
  logic [IDX_W-1:0]   miss_slot;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [PAGE_W-1:0]  ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !ctl.ld;
  assign accept      = in_valid_i && ctl.ld;

  always_comb begin
    if (cfg_q == '0) begin
      n_act = CNT_W'(1);
    end else if (cfg_q > CFG_W'(FRAMES)) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(cfg_q);
    end
    limit_act = (filled_q < n_act) ? filled_q : n_act;
  end

  assign sts.accept   = accept;
  assign sts.empty    = (limit_q == '0);
  assign sts.match    = (ram_rdata == page_q);
  assign sts.last     = (addr_q == limit_q);
  assign sts.out_free = !out_valid_q || !out_stall_i;

  assign scan_go = ctl.scan && !sts.match && !sts.last;
  assign emit_go = ctl.emit && sts.out_free;

  assign fill      = (filled_q < n_q);
  assign ptr_use   = (CNT_W'(ptr_q) >= n_q) ? '0 : ptr_q;
  assign ptr_inc   = CNT_W'(ptr_use) + CNT_W'(1);
  assign miss_slot = fill ? filled_q[IDX_W-1:0] : ptr_use;

  assign ram_re    = ctl.rd0 || scan_go;
  assign ram_raddr = ctl.rd0 ? '0 : addr_q[IDX_W-1:0];

  fpr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  fpr_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (FRAMES)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (ctl.miss),
    .waddr_i (miss_slot),
    .wdata_i (page_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= FRAME_COUNT_RESET;
      filled_q    <= '0;
      ptr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_frame_count_i;
      end
      if (ctl.miss) begin
        if (count_q != '1) begin
          count_q <= count_q + TOTAL_W'(1);
        end
        if (fill) begin
          filled_q <= filled_q + CNT_W'(1);
        end else begin
          ptr_q <= (ptr_inc >= n_q) ? '0 : ptr_inc[IDX_W-1:0];
        end
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q  <= page_i;
      n_q     <= n_act;
      limit_q <= limit_act;
    end
    if (ctl.rd0) begin
      addr_q <= CNT_W'(1);
    end else if (scan_go) begin
      addr_q <= addr_q + CNT_W'(1);
    end
    if (ctl.hit) begin
      fault_q <= 1'b0;
      slot_q  <= IDX_W'(addr_q - CNT_W'(1));
    end else if (ctl.miss) begin
      fault_q <= 1'b1;
      slot_q  <= miss_slot;
    end
    if (emit_go) begin
      fault_o       <= fault_q;
      slot_o        <= slot_q;
      fault_total_o <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.miss |-> (CNT_W'(miss_slot) < n_q))
    else $error("frame write outside the active frames");

  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(FRAMES))
    else $error("fill count beyond frame depth");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q >= $past(count_q)))
    else $error("fault total decreased");

  a_hit_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.hit |=> (count_q == $past(count_q)) && (filled_q == $past(filled_q)))
    else $error("state changed on a hit");

endmodule

// File: tb/tb_fifo_page_replacement.sv
// Self-checking testbench for fifo_page_replacement: directed and random page references
// under varied frame counts, idling and output hold-off, each result checked in order.
// Depends on fpr_pkg and the fifo_page_replacement RTL.
module tb_fifo_page_replacement;

  typedef struct packed {
    logic                        fault;
    logic [fpr_pkg::IDX_W-1:0]   slot;
    logic [fpr_pkg::TOTAL_W-1:0] total;
  } page_outcome_t;

  logic                        clk_i             = 1'b0;
  logic                        rst_ni            = 1'b0;
  logic                        in_valid_i        = 1'b0;
  logic                        in_stall_o;
  logic [fpr_pkg::PAGE_W-1:0]  page_i            = '0;
  logic                        out_valid_o;
  logic                        out_stall_i       = 1'b0;
  logic                        fault_o;
  logic [fpr_pkg::IDX_W-1:0]   slot_o;
  logic [fpr_pkg::TOTAL_W-1:0] fault_total_o;
  logic                        cfg_valid_i       = 1'b0;
  logic                        cfg_ready_o;
  logic [fpr_pkg::CFG_W-1:0]   cfg_frame_count_i = '0;

  logic [fpr_pkg::PAGE_W-1:0]  resident_pages [fpr_pkg::FRAMES];
  int unsigned                 filled_frames;
  int unsigned                 fifo_pointer;
  logic [fpr_pkg::TOTAL_W-1:0] faults_seen;
  logic [fpr_pkg::CFG_W-1:0]   frame_count_q;

  page_outcome_t pending_outcomes[$];
  page_outcome_t want;

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_left    = 0;
  int errors       = 0;
  int n_checked    = 0;
  int n_sent       = 0;
  int n_cfg_writes = 0;

  fifo_page_replacement i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .page_i           (page_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fault_o          (fault_o),
    .slot_o           (slot_o),
    .fault_total_o    (fault_total_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_frame_count_i(cfg_frame_count_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned active_count();
    int unsigned n;
    n = 32'(frame_count_q);
    if (n == 0) n = 1;
    if (n > fpr_pkg::FRAMES) n = fpr_pkg::FRAMES;
    return n;
  endfunction

  function automatic page_outcome_t resolve_reference(input logic [fpr_pkg::PAGE_W-1:0] p);
    int unsigned   n;
    int unsigned   lim;
    int unsigned   slot;
    logic          hit;
    page_outcome_t r;
    n    = active_count();
    lim  = (filled_frames < n) ? filled_frames : n;
    hit  = 1'b0;
    slot = 0;
    for (int unsigned i = 0; i < lim; i++) begin
      if (!hit && resident_pages[i] == p) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    if (!hit) begin
      if (faults_seen != '1) faults_seen = faults_seen + 1;
      if (filled_frames < n) begin
        slot = filled_frames;
        filled_frames++;
      end else begin
        if (fifo_pointer >= n) fifo_pointer = 0;
        slot = fifo_pointer;
        fifo_pointer = (fifo_pointer + 1 >= n) ? 0 : fifo_pointer + 1;
      end
      resident_pages[slot] = p;
    end
    r.fault = ~hit;
    r.slot  = slot[fpr_pkg::IDX_W-1:0];
    r.total = faults_seen;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_outcomes.push_back(resolve_reference(page_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        $error("result without a pending request: fault %0d slot %0d total %0d",
               fault_o, slot_o, fault_total_o);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        n_checked++;
        if (fault_o !== want.fault) begin
          $error("fault mismatch: expected %0d, actual %0d", want.fault, fault_o);
          errors++;
        end
        if (slot_o !== want.slot) begin
          $error("slot mismatch: expected %0d, actual %0d", want.slot, slot_o);
          errors++;
        end
        if (fault_total_o !== want.total) begin
          $error("fault_total mismatch: expected %0d, actual %0d", want.total, fault_total_o);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < rx_idle_pct);
    end
  end

  task automatic send_page(input logic [fpr_pkg::PAGE_W-1:0] p);
    int gap;
    gap = ($urandom_range(99, 0) < tx_idle_pct) ? $urandom_range(4, 1) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      page_i     <= 16'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    page_i     <= p;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_frame_count(input logic [fpr_pkg::CFG_W-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_frame_count_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    frame_count_q = v;
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i       <= 1'b0;
    cfg_frame_count_i <= 5'($urandom);
  endtask

  task automatic test_reset_default();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h0005);
    send_page(16'h0007);
    send_page(16'h0000);
  endtask

  task automatic test_count_raised();
    write_frame_count(5'd8);
    send_page(16'h0100);
    send_page(16'h0007);
    send_page(16'h0200);
    send_page(16'hFFFF);
  endtask

  task automatic test_zero_count();
    write_frame_count(5'd0);
    send_page(16'h0007);
    send_page(16'h0300);
    send_page(16'h0300);
  endtask

  task automatic test_count_above_depth();
    write_frame_count(5'd31);
    for (int i = 0; i < 8; i++) send_page(16'(16'h1000 + i));
    send_page(16'hABCD);
  endtask

  task automatic test_count_lowered();
    write_frame_count(5'd5);
    send_page(16'h1003);
    send_page(16'h2000);
    send_page(16'h2001);
  endtask

  task automatic test_output_hold_off();
    write_frame_count(5'd4);
    @(posedge clk_i);
    hold_left = 150;
    for (int i = 0; i < 10; i++) send_page(16'($urandom_range(7, 0)));
  endtask

  task automatic test_random_references(input int tx_pct, input int rx_pct, input int items);
    int          done;
    int          seg;
    int unsigned pool;
    logic [15:0] base;
    logic [4:0]  fc;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    done = 0;
    while (done < items) begin
      case ($urandom_range(5, 0))
        0:       fc = 5'd1;
        1:       fc = 5'd16;
        2:       fc = 5'd0;
        3:       fc = 5'($urandom_range(31, 17));
        default: fc = 5'($urandom_range(16, 1));
      endcase
      write_frame_count(fc);
      seg  = $urandom_range(50, 30);
      pool = active_count() + $urandom_range(3, 0);
      base = 16'($urandom);
      for (int i = 0; i < seg; i++) begin
        if ($urandom_range(99, 0) < 85) send_page(16'(base + $urandom_range(pool - 1, 0)));
        else send_page(16'($urandom));
      end
      done += seg;
    end
  endtask

  initial begin
    foreach (resident_pages[i]) resident_pages[i] = '0;
    filled_frames = 0;
    fifo_pointer  = 0;
    faults_seen   = '0;
    frame_count_q = fpr_pkg::FRAME_COUNT_RESET;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    tx_idle_pct = 18;
    rx_idle_pct = 46;
    test_reset_default();
    test_count_raised();
    test_zero_count();
    test_count_above_depth();
    test_count_lowered();
    test_output_hold_off();
    test_random_references(18, 46, 170);
    test_random_references(46, 18, 170);
    test_random_references(0, 0, 170);
    drain();
    repeat (30) @(posedge clk_i);
    $display("summary: %0d page references sent, %0d results checked, %0d frame count writes",
             n_sent, n_checked, n_cfg_writes);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("tb: failure");
    $finish;
  end

endmodule
